// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/vtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Voidage conductivity package
// Shared widths and the cell-to-cell data word of the compute chain.
// ----------------------------------------------------------------------------
package vtc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int VF_W = 17;
	localparam int KF_W = 32;
	localparam int RAD_W = 2 * FRAC_BITS;
	localparam int ROOT_W = FRAC_BITS + 1;
	localparam int REM_W = FRAC_BITS + 3;
	localparam int NUM_W = 2 * FRAC_BITS + 1;
	localparam int RAT_W = FRAC_BITS + 1;
	localparam int SQRT_STEPS = FRAC_BITS;
	localparam int DIV_STEPS = FRAC_BITS + 1;

	typedef enum logic [1:0] {
		CASE_NORMAL = 2'd0,
		CASE_FULL   = 2'd1,
		CASE_ZERO   = 2'd2
	} case_t;

	typedef struct packed {
		logic               valid;
		case_t              kind;
		logic [VF_W-1:0]    e;
		logic [KF_W-1:0]    kf;
		logic [RAD_W-1:0]   rad;
		logic [REM_W-1:0]   rem;
		logic [ROOT_W-1:0]  root;
		logic [NUM_W-1:0]   num;
		logic [RAT_W-1:0]   quo;
	} cell_t;
endpackage

// ===== hw/rtl/vtc_if.sv =====
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for void fraction, conductivity and configuration.
// ----------------------------------------------------------------------------
interface vtc_vf_if;
	logic        valid;
	logic        ready;
	logic [16:0] void_fraction;
	modport source (output valid, output void_fraction, input ready);
	modport sink (input valid, input void_fraction, output ready);
endinterface

interface vtc_k_if;
	logic        valid;
	logic        ready;
	logic [31:0] conductivity;
	modport source (output valid, output conductivity, input ready);
	modport sink (input valid, input conductivity, output ready);
endinterface

interface vtc_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/vtc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step on a radicand digit pair per cycle while en is high.
// ----------------------------------------------------------------------------
module vtc_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  vtc_pkg::cell_t d,
	output vtc_pkg::cell_t q
);
	import vtc_pkg::*;

	logic [REM_W-1:0]  trial_rem;
	logic [REM_W-1:0]  trial;
	cell_t             nxt;

	always_comb begin
		nxt = d;
		trial_rem = {d.rem[REM_W-3:0], d.rad[RAD_W-1 -: 2]};
		trial = {d.root, 2'b01};
		nxt.rad = {d.rad[RAD_W-3:0], 2'b00};
		if (trial_rem >= trial) begin
			nxt.rem = trial_rem - trial;
			nxt.root = {d.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem = trial_rem;
			nxt.root = {d.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end
endmodule

// ===== hw/rtl/vtc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divide cell
// One restoring division step producing one quotient bit per cycle while en is high.
// ----------------------------------------------------------------------------
module vtc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  vtc_pkg::cell_t d,
	output vtc_pkg::cell_t q
);
	import vtc_pkg::*;

	logic [VF_W:0] part;
	cell_t         nxt;

	always_comb begin
		nxt = d;
		part = {d.rem[VF_W-1:0], d.num[NUM_W-1]};
		nxt.num = {d.num[NUM_W-2:0], 1'b0};
		if (part >= {1'b0, d.e}) begin
			nxt.rem = REM_W'(part - {1'b0, d.e});
			nxt.quo = {d.quo[RAT_W-2:0], 1'b1};
		end else begin
			nxt.rem = REM_W'(part);
			nxt.quo = {d.quo[RAT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end
endmodule

// ===== hw/rtl/voidage_thermal_conductivity.sv =====
// One transaction is accepted per cycle while the output is not held. The compute
// chain has 16 square root cells and 17 divide cells, each resolving one bit per
// cycle, followed by the saturate, multiply and result registers.
// The whole chain stalls together when the output is held.
// Reset clears all valid flags and loads the conductivity register with 1.0.
module voidage_thermal_conductivity (
	input logic     clk,
	input logic     arst_n,
	vtc_vf_if.sink  vf_in,
	vtc_k_if.source k_out,
	vtc_cfg_if.sink cfg
);
	import vtc_pkg::*;

	localparam int NCELL = SQRT_STEPS + DIV_STEPS;

	logic [KF_W-1:0] kf_q;
	logic            en;
	cell_t           head;
	cell_t           mid;
	logic [ROOT_W-1:0] numr;
	cell_t           chain [NCELL+1];
	cell_t           tail_s1;
	logic [RAT_W-1:0] ratio_s2;
	logic [KF_W-1:0]  kf_s2;
	case_t            kind_s2;
	logic             valid_s2;
	logic [RAT_W+KF_W-1:0] prod_s3;
	case_t            kind_s3;
	logic [KF_W-1:0]  kf_s3;
	logic             valid_s3;
	logic [KF_W-1:0]  res_q;
	logic             res_valid_q;
	logic [RAT_W-1:0] rsat;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kf_q <= KF_W'(65536);
		end else if (cfg.valid) begin
			kf_q <= cfg.data;
		end
	end

	assign en = !res_valid_q || k_out.ready;
	assign vf_in.ready = en;

	always_comb begin
		head = '0;
		head.valid = vf_in.valid;
		head.e = vf_in.void_fraction;
		head.kf = kf_q;
		if (vf_in.void_fraction >= VF_W'(1 << FRAC_BITS)) begin
			head.kind = CASE_FULL;
		end else if (vf_in.void_fraction == '0) begin
			head.kind = CASE_ZERO;
		end else begin
			head.kind = CASE_NORMAL;
		end
		head.rad = {FRAC_BITS'(VF_W'(1 << FRAC_BITS) - vf_in.void_fraction),
			FRAC_BITS'(0)};
	end
	assign chain[0] = head;

	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		vtc_sqrt_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en),
			.d(chain[i]), .q(chain[i+1]));
	end

	// The dividend is the numerator shifted up by FRAC_BITS. Its upper bits
	// preload the remainder so that the divide cells produce the low quotient bits.
	always_comb begin
		mid = chain[SQRT_STEPS];
		numr = ROOT_W'(1 << FRAC_BITS) - mid.root;
		mid.rem = REM_W'(numr >> 1);
		mid.quo = '0;
		mid.num = {numr[0], (NUM_W-1)'(0)};
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		if (i == 0) begin : g_first
			vtc_div_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(mid), .q(chain[SQRT_STEPS+1]));
		end else begin : g_rest
			vtc_div_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en),
				.d(chain[SQRT_STEPS+i]), .q(chain[SQRT_STEPS+i+1]));
		end
	end

	assign tail_s1 = chain[NCELL];
	assign rsat = (tail_s1.quo > RAT_W'(1 << FRAC_BITS)) ? RAT_W'(1 << FRAC_BITS)
		: tail_s1.quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			valid_s2 <= tail_s1.valid;
			valid_s3 <= valid_s2;
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s2 <= rsat;
			kf_s2 <= tail_s1.kf;
			kind_s2 <= tail_s1.kind;
			prod_s3 <= ratio_s2 * kf_s2;
			kind_s3 <= kind_s2;
			kf_s3 <= kf_s2;
			case (kind_s3)
				CASE_FULL: res_q <= kf_s3;
				CASE_ZERO: res_q <= '0;
				default:   res_q <= prod_s3[FRAC_BITS +: KF_W];
			endcase
		end
	end

	assign k_out.valid = res_valid_q;
	assign k_out.conductivity = res_q;
endmodule

// ===== hw/rtl/vtc_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level ports for handshake and result range rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module vtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_data,
	input logic        cfg_valid,
	input logic [31:0] cfg_data
);
	logic [31:0] kf_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kf_q <= 32'd65536;
		end else if (cfg_valid) begin
			kf_q <= cfg_data;
		end
	end

	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`ASSERT_IMPL(a_range, clk, arst_n, out_valid, out_data <= kf_q)
	`ASSERT_IMPL(a_ready, clk, arst_n, !out_valid, in_ready)
	`ASSERT_IMPL(a_stall, clk, arst_n, out_valid && !out_ready, !in_ready)
endmodule

bind voidage_thermal_conductivity vtc_checker u_vtc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(vf_in.valid), .in_ready(vf_in.ready),
	.out_valid(k_out.valid), .out_ready(k_out.ready), .out_data(k_out.conductivity),
	.cfg_valid(cfg.valid), .cfg_data(cfg.data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voidage conductivity testbench
// Drives void fractions and conductivity register writes into the block and
// checks each result against a fixed-point model held in a scoreboard.
// ----------------------------------------------------------------------------
class vtc_scoreboard;
	logic [31:0] kf;
	logic [31:0] pending[$];
	int mismatches;
	int checked;

	function new();
		kf = 32'd65536;
		mismatches = 0;
		checked = 0;
	endfunction

	function logic [31:0] conductivity_of(logic [16:0] e);
		logic [63:0] v;
		logic [63:0] root;
		logic [63:0] bitv;
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] one;
		one = 64'd1 << vtc_pkg::FRAC_BITS;
		if (e >= one)
			return kf;
		if (e == 0)
			return 32'd0;
		v = (one - e) << vtc_pkg::FRAC_BITS;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v = v - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		n = one - root;
		r = (n << vtc_pkg::FRAC_BITS) / e;
		if (r > one)
			r = one;
		return 32'((r * kf) >> vtc_pkg::FRAC_BITS);
	endfunction

	function void note_cell(logic [16:0] e);
		pending.push_back(conductivity_of(e));
	endfunction

	function void check_conductivity(logic [31:0] got);
		logic [31:0] want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected conductivity %0d", got);
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("conductivity mismatch: expected %0d, got %0d", want, got);
		end
	endfunction
endclass

module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycles = 0;
	int idle_pct = 38;
	bit hold_off = 1'b0;
	int sent = 0;
	vtc_scoreboard sb;

	vtc_vf_if vf_in ();
	vtc_k_if k_out ();
	vtc_cfg_if cfg ();

	voidage_thermal_conductivity i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.vf_in(vf_in),
		.k_out(k_out),
		.cfg(cfg)
	);

	always #6 clk = ~clk;

	initial begin
		vf_in.valid = 1'b0;
		vf_in.void_fraction = '0;
		k_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("voidage_thermal_conductivity verification failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && k_out.valid && k_out.ready)
			sb.check_conductivity(k_out.conductivity);
	end

	always @(negedge clk) begin
		if (!arst_n || hold_off)
			k_out.ready <= 1'b0;
		else
			k_out.ready <= ($urandom_range(99) >= idle_pct);
	end

	task automatic send_cell(logic [16:0] e);
		while ($urandom_range(99) < idle_pct) begin
			vf_in.valid <= 1'b0;
			@(negedge clk);
		end
		vf_in.valid <= 1'b1;
		vf_in.void_fraction <= e;
		@(posedge clk);
		while (!vf_in.ready)
			@(posedge clk);
		sb.note_cell(e);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		vf_in.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_kf(logic [31:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		sb.kf = value;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	function automatic logic [16:0] random_fraction();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(16));
			3: return 17'(65536 - $urandom_range(16));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	initial begin
		logic [31:0] settings[6];
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		settings = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'h8000_0000, 32'h0001_8000, 32'h1234_5678};
		send_cell(17'd0);
		send_cell(17'd1);
		send_cell(17'd2);
		send_cell(17'd65535);
		send_cell(17'd65536);
		send_cell(17'd32768);
		send_cell(17'h15555);
		send_cell(17'h0AAAA);
		send_cell(17'h1FFFF & 17'd65536);
		send_cell(17'd16384);
		write_kf(32'hFFFF_FFFF);
		send_cell(17'd1);
		send_cell(17'd65535);
		send_cell(17'd65536);
		send_cell(17'd40000);
		for (int p = 0; p < 6; p++) begin
			write_kf(p == 5 ? $urandom : settings[p]);
			if (p == 2) begin
				idle_pct = 0;
				repeat (200) send_cell(random_fraction());
				idle_pct = 38;
			end
			if (p == 3) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (150) @(posedge clk);
						hold_off = 1'b0;
					end
					repeat (60) send_cell(random_fraction());
				join
			end
			repeat (263) send_cell(random_fraction());
			drain();
		end
		drain();
		$display("Sent %0d void fractions over eight conductivity settings; checked %0d results.",
			sent, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("voidage_thermal_conductivity verification clean");
		else
			$display("voidage_thermal_conductivity verification failed");
		$finish;
	end
endmodule

// ===== voidage_thermal_conductivity.f =====
+incdir+hw/rtl
hw/rtl/vtc_pkg.sv
hw/rtl/vtc_if.sv
hw/rtl/vtc_sqrt_cell.sv
hw/rtl/vtc_div_cell.sv
hw/rtl/voidage_thermal_conductivity.sv
hw/rtl/vtc_checker.sv
verif/tb_top.sv
